### sv/itew_pkg.sv
// ----------------------------------------------------------------------------
// itew_pkg
// Shared widths, token codes, slot codes and types for the integer to
// English word token block.
// ----------------------------------------------------------------------------
package itew_pkg;

  // Widths of the channel payload.
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned WORD_W  = 5;

  // Decimal form of a value: ten BCD digits hold up to 2147483647.
  localparam int unsigned DIGITS  = 10;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned BIN_W   = 32;

  // The converter retires two binary bits per cycle.
  localparam int unsigned CONV_STEPS = BIN_W / 2;
  localparam int unsigned CONV_CNT_W = $clog2(CONV_STEPS);

  // Word slots: eight per group (billions group first), five used in each upper
  // group, four in the units group plus one slot there for the lone Zero word.
  localparam int unsigned GROUPS    = 4;
  localparam int unsigned SLOT_SPAN = 8;
  localparam int unsigned SLOTS     = GROUPS * SLOT_SPAN;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);

  localparam logic [2:0] SL_HUND_DIGIT = 3'd0;
  localparam logic [2:0] SL_HUNDRED    = 3'd1;
  localparam logic [2:0] SL_TENS       = 3'd2;
  localparam logic [2:0] SL_ONES       = 3'd3;
  localparam logic [2:0] SL_SCALE      = 3'd4;
  localparam logic [2:0] SL_ZERO       = 3'd5;

  localparam logic [1:0] GRP_BILLIONS  = 2'd0;
  localparam logic [1:0] GRP_MILLIONS  = 2'd1;
  localparam logic [1:0] GRP_THOUSANDS = 2'd2;
  localparam logic [1:0] GRP_UNITS     = 2'd3;

  localparam int unsigned ZERO_SLOT = 3 * SLOT_SPAN + 5;

  // Word token codes.
  localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] TOK_TEEN_BASE = 5'd10;
  localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
  localparam logic [WORD_W-1:0] TOK_THOUSAND  = 5'd29;
  localparam logic [WORD_W-1:0] TOK_MILLION   = 5'd30;
  localparam logic [WORD_W-1:0] TOK_BILLION   = 5'd31;

  // Depth of the queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // One classified value as it waits in the queue.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [SLOTS-1:0] mask;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Returns one digit of a group: pos 0 ones, 1 tens, 2 hundreds. Digits
  // above the top of the BCD word read as zero.
  function automatic logic [3:0] group_digit(input logic [BCD_W-1:0] bcd,
                                             input logic [1:0] grp,
                                             input logic [1:0] pos);
    logic [3:0] base;
    logic [3:0] idx;
    begin
      case (grp)
        GRP_BILLIONS:  base = 4'd9;
        GRP_MILLIONS:  base = 4'd6;
        GRP_THOUSANDS: base = 4'd3;
        default:       base = 4'd0;
      endcase
      idx = base + {2'b00, pos};
      if (idx >= 4'(DIGITS)) begin
        group_digit = 4'd0;
      end else begin
        group_digit = bcd[{idx, 2'b00} +: 4];
      end
    end
  endfunction

endpackage

### sv/itew_ifs.sv
// ----------------------------------------------------------------------------
// itew channel interfaces
// Valid/ready channels for the input values and the output word tokens.
// ----------------------------------------------------------------------------

// Input channel: one value per word.
interface itew_in_if;
  logic                          valid;
  logic                          ready;
  logic [itew_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one token per word, last marks the end of a value.
interface itew_out_if;
  logic                          valid;
  logic                          ready;
  logic [itew_pkg::WORD_W-1:0]   word;
  logic                          last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

### sv/integer_to_english_word_tokens.sv
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens
// A new value is accepted only once the binary to BCD converter, which
// retires two bits per cycle, has finished the last one; the back part
// sends the word tokens of one value while the next one is converted.
// Reset: synchronous active-low rst_n empties the queue and idles both parts.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens (
  input  logic        clk,
  input  logic        rst_n,
  itew_in_if.sink     in_ch,
  itew_out_if.source  out_ch
);

  logic                 push;
  logic                 pop;
  itew_pkg::job_t       push_job;
  itew_pkg::job_t       pop_job;
  itew_pkg::q_stat_t    q_stat;

  // Front part: accept, convert and classify.
  itew_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_job (push_job),
    .q_stat   (q_stat)
  );

  // Queue between the two parts.
  itew_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // Back part: emit the word tokens.
  itew_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_job  (pop_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### sv/itew_front.sv
// ----------------------------------------------------------------------------
// itew_front
// Accepts a value, converts it to BCD two bits per cycle and classifies
// which word slots it fills, then pushes the result into the queue.
// ----------------------------------------------------------------------------
module itew_front (
  input  logic                 clk,
  input  logic                 rst_n,
  itew_in_if.sink              in_ch,
  output logic                 push,
  output itew_pkg::job_t       push_job,
  input  itew_pkg::q_stat_t    q_stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PUSH
  } state_t;

  localparam int unsigned CAT_W = itew_pkg::BCD_W + itew_pkg::BIN_W;

  state_t                              state_r;
  logic [itew_pkg::CONV_CNT_W-1:0]     cnt_r;
  logic [itew_pkg::BIN_W-1:0]          bin_r;
  logic [itew_pkg::BCD_W-1:0]          bcd_r;
  logic [itew_pkg::BIN_W-1:0]          bin_nxt;
  logic [itew_pkg::BCD_W-1:0]          bcd_nxt;
  logic                                accept;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic logic [CAT_W-1:0] dabble(input logic [CAT_W-1:0] x);
    logic [CAT_W-1:0] y;
    logic [3:0]       d;
    begin
      y = x;
      for (int i = 0; i < int'(itew_pkg::DIGITS); i++) begin
        d = y[itew_pkg::BIN_W + 4*i +: 4];
        if (d >= 4'd5) begin
          y[itew_pkg::BIN_W + 4*i +: 4] = d + 4'd3;
        end
      end
      dabble = {y[CAT_W-2:0], 1'b0};
    end
  endfunction

  // Marks every word slot that this value emits.
  function automatic logic [itew_pkg::SLOTS-1:0] classify(
      input logic [itew_pkg::BCD_W-1:0] bcd);
    logic [itew_pkg::SLOTS-1:0] m;
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
    begin
      m = '0;
      for (int g = 0; g < int'(itew_pkg::GROUPS); g++) begin
        h = itew_pkg::group_digit(bcd, 2'(g), 2'd2);
        t = itew_pkg::group_digit(bcd, 2'(g), 2'd1);
        o = itew_pkg::group_digit(bcd, 2'(g), 2'd0);
        m[g*itew_pkg::SLOT_SPAN + int'(itew_pkg::SL_HUND_DIGIT)] = (h != 4'd0);
        m[g*itew_pkg::SLOT_SPAN + int'(itew_pkg::SL_HUNDRED)]    = (h != 4'd0);
        m[g*itew_pkg::SLOT_SPAN + int'(itew_pkg::SL_TENS)]       = (t != 4'd0) || (o != 4'd0);
        m[g*itew_pkg::SLOT_SPAN + int'(itew_pkg::SL_ONES)]       = (t >= 4'd2) && (o != 4'd0);
        m[g*itew_pkg::SLOT_SPAN + int'(itew_pkg::SL_SCALE)]      =
            (2'(g) != itew_pkg::GRP_UNITS) && ((h | t | o) != 4'd0);
      end
      m[itew_pkg::ZERO_SLOT] = (bcd == '0);
      classify = m;
    end
  endfunction

  // Two conversion steps per cycle.
  assign {bcd_nxt, bin_nxt} = dabble(dabble({bcd_r, bin_r}));

  // Handshake: a new value may enter as the finished one leaves.
  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_PUSH) && !q_stat.full);
  assign accept      = in_ch.valid && in_ch.ready;

  assign push          = (state_r == S_PUSH) && !q_stat.full;
  assign push_job.bcd  = bcd_r;
  assign push_job.mask = classify(bcd_r);

  // Sequencer and conversion registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CONV;
            bin_r   <= {1'b0, in_ch.value};
            bcd_r   <= '0;
            cnt_r   <= '0;
          end
        end
        S_CONV: begin
          bin_r <= bin_nxt;
          bcd_r <= bcd_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == itew_pkg::CONV_CNT_W'(itew_pkg::CONV_STEPS - 1)) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (accept) begin
            state_r <= S_CONV;
            bin_r   <= {1'b0, in_ch.value};
            bcd_r   <= '0;
            cnt_r   <= '0;
          end else if (push) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/itew_queue.sv
// ----------------------------------------------------------------------------
// itew_queue
// Short FIFO of classified values between the front and back parts.
// ----------------------------------------------------------------------------
module itew_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  itew_pkg::job_t       push_job,
  input  logic                 pop,
  output itew_pkg::job_t       pop_job,
  output itew_pkg::q_stat_t    stat
);

  itew_pkg::job_t                  mem [itew_pkg::Q_DEPTH];
  logic [itew_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [itew_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [itew_pkg::Q_PTR_W:0]      cnt_r;

  assign stat.full  = (cnt_r == (itew_pkg::Q_PTR_W + 1)'(itew_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_job    = mem[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### sv/itew_back.sv
// ----------------------------------------------------------------------------
// itew_back
// Walks the marked word slots of one value, lowest slot first, and sends
// one token word per cycle, while out_ch is ready, through a registered output.
// ----------------------------------------------------------------------------
module itew_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itew_pkg::job_t       pop_job,
  input  itew_pkg::q_stat_t    q_stat,
  output logic                 pop,
  itew_out_if.source           out_ch
);

  logic                              busy_r;
  logic [itew_pkg::SLOTS-1:0]        mask_r;
  logic [itew_pkg::BCD_W-1:0]        bcd_r;
  logic                              out_valid_r;
  logic [itew_pkg::WORD_W-1:0]       out_word_r;
  logic                              out_last_r;

  logic [itew_pkg::SLOT_W-1:0]       sel;
  logic [1:0]                        grp;
  logic [2:0]                        slot;
  logic [3:0]                        hund;
  logic [3:0]                        tens;
  logic [3:0]                        ones;
  logic [itew_pkg::WORD_W-1:0]       word_nxt;
  logic [itew_pkg::SLOTS-1:0]        mask_nxt;
  logic                              emit;
  logic                              emit_last;

  // Lowest marked slot comes first.
  always_comb begin
    sel = '0;
    for (int i = int'(itew_pkg::SLOTS) - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = itew_pkg::SLOT_W'(i);
      end
    end
  end

  assign grp  = sel[itew_pkg::SLOT_W-1 -: 2];
  assign slot = sel[2:0];
  assign hund = itew_pkg::group_digit(bcd_r, grp, 2'd2);
  assign tens = itew_pkg::group_digit(bcd_r, grp, 2'd1);
  assign ones = itew_pkg::group_digit(bcd_r, grp, 2'd0);

  // Token for the selected slot.
  always_comb begin
    case (slot)
      itew_pkg::SL_HUND_DIGIT: word_nxt = itew_pkg::WORD_W'(hund);
      itew_pkg::SL_HUNDRED:    word_nxt = itew_pkg::TOK_HUNDRED;
      itew_pkg::SL_TENS: begin
        if (tens >= 4'd2) begin
          word_nxt = itew_pkg::TOK_TENS_BASE + itew_pkg::WORD_W'(tens);
        end else if (tens != 4'd0) begin
          word_nxt = itew_pkg::TOK_TEEN_BASE + itew_pkg::WORD_W'(ones);
        end else begin
          word_nxt = itew_pkg::WORD_W'(ones);
        end
      end
      itew_pkg::SL_ONES:       word_nxt = itew_pkg::WORD_W'(ones);
      itew_pkg::SL_SCALE: begin
        case (grp)
          itew_pkg::GRP_BILLIONS: word_nxt = itew_pkg::TOK_BILLION;
          itew_pkg::GRP_MILLIONS: word_nxt = itew_pkg::TOK_MILLION;
          default:                word_nxt = itew_pkg::TOK_THOUSAND;
        endcase
      end
      itew_pkg::SL_ZERO:       word_nxt = itew_pkg::TOK_ZERO;
      default:                 word_nxt = itew_pkg::TOK_ZERO;
    endcase
  end

  // A word goes out when the output register is free or being drained.
  assign mask_nxt  = mask_r & ~(itew_pkg::SLOTS'(1) << sel);
  assign emit      = busy_r && (!out_valid_r || out_ch.ready);
  assign emit_last = (mask_nxt == '0);
  assign pop       = !busy_r && !q_stat.empty;

  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;
  assign out_ch.last  = out_last_r;

  // Slot walker and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        mask_r <= pop_job.mask;
        bcd_r  <= pop_job.bcd;
      end
      if (emit) begin
        mask_r      <= mask_nxt;
        out_word_r  <= word_nxt;
        out_last_r  <= emit_last;
        out_valid_r <= 1'b1;
        if (emit_last) begin
          busy_r <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A value being walked always has a word left to send.
  a_busy_has_slots: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (mask_r != '0))
    else $error("itew_back: busy with no slots left");

  // Sending the last word frees the walker.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> !busy_r)
    else $error("itew_back: still busy after last word");

  // The Zero word never shares a value with other words.
  a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && mask_r[itew_pkg::ZERO_SLOT]) |-> $onehot(mask_r))
    else $error("itew_back: Zero word mixed with other words");

endmodule
